// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
// Types and codes of the sorted priority queue
package spq_pkg;

    localparam int OP_W    = 1;
    localparam int PRIO_W  = 16;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] payload;
        logic [PRIO_W-1:0] priority_req;
        logic [OP_W-1:0]   operation;
    } t_req;

    typedef struct packed {
        logic                is_empty;
        logic [TOTAL_W-1:0]  entry_total;
        logic [DATA_W-1:0]   head_payload;
        logic [PRIO_W-1:0]   head_priority;
        logic [STAT_W-1:0]   status;
    } t_result;

endpackage

// ===== sv/spq_ctrl.sv =====
// Sequencer of the sorted priority queue: request, compare, commit
module spq_ctrl import spq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept, w_commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_commit    = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_comb begin
        o_cmd.load    = w_accept;
        o_cmd.compare = (r_state == S_CMP);
        o_cmd.commit  = w_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/spq_table.sv =====
// Datapath of the sorted priority queue: slot table, compare flags, result register
module spq_table import spq_pkg::*; #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 16,
    parameter int PAYLOAD_BITS  = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_req    i_req,
    output t_result o_result
);

    localparam int PW = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
    localparam int DW = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [OP_W-1:0] r_op;
    logic [PW-1:0]   r_prio;
    logic [DW-1:0]   r_data;
    logic [PW-1:0]   r_slot_prio [CAPACITY];
    logic [DW-1:0]   r_slot_data [CAPACITY];
    logic [CW-1:0]   r_count, n_count;
    logic            r_gt [CAPACITY];
    logic            r_found;
    t_result         r_result;

    logic            w_valid [CAPACITY];
    logic            w_eq    [CAPACITY];
    logic [PW-1:0]   w_up_prio [CAPACITY];
    logic [DW-1:0]   w_up_data [CAPACITY];
    logic [PW-1:0]   w_dn_prio [CAPACITY];
    logic [DW-1:0]   w_dn_data [CAPACITY];
    logic            w_ins_here [CAPACITY];
    logic            w_full, w_any_eq;
    logic [PW-1:0]   w_head_prio;
    logic [DW-1:0]   w_head_data;
    logic [STAT_W-1:0] w_status;

    assign w_full = (r_count == CW'(CAPACITY));

    always_comb begin
        w_any_eq = 1'b0;
        for (int j = 0; j < CAPACITY; j++) begin
            w_valid[j] = (CW'(j) < r_count);
            w_eq[j]    = w_valid[j] && (r_slot_prio[j] == r_prio);
            w_any_eq   = w_any_eq | w_eq[j];
        end
    end

    for (genvar j = 0; j < CAPACITY; j++) begin : g_slot
        if (j == 0) begin : g_first
            assign w_up_prio[j]  = r_prio;
            assign w_up_data[j]  = r_data;
            assign w_ins_here[j] = !r_gt[j];
        end else begin : g_rest
            assign w_up_prio[j]  = r_slot_prio[j-1];
            assign w_up_data[j]  = r_slot_data[j-1];
            assign w_ins_here[j] = !r_gt[j] && r_gt[j-1];
        end
        if (j == CAPACITY - 1) begin : g_last
            assign w_dn_prio[j] = r_slot_prio[j];
            assign w_dn_data[j] = r_slot_data[j];
        end else begin : g_inner
            assign w_dn_prio[j] = r_slot_prio[j+1];
            assign w_dn_data[j] = r_slot_data[j+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.compare) begin
                r_gt[j] <= w_valid[j] && (r_slot_prio[j] > r_prio);
            end
            if (i_cmd.commit) begin
                if (r_op == OP_INSERT) begin
                    if (!w_full && !r_gt[j]) begin
                        r_slot_prio[j] <= w_ins_here[j] ? r_prio : w_up_prio[j];
                        r_slot_data[j] <= w_ins_here[j] ? r_data : w_up_data[j];
                    end
                end else if (r_found && !r_gt[j]) begin
                    r_slot_prio[j] <= w_dn_prio[j];
                    r_slot_data[j] <= w_dn_data[j];
                end
            end
        end
    end

    always_comb begin
        n_count     = r_count;
        w_head_prio = r_slot_prio[0];
        w_head_data = r_slot_data[0];
        if (r_op == OP_INSERT) begin
            w_status = w_full ? ST_FULL : ST_DONE;
            if (!w_full) begin
                n_count = r_count + CW'(1);
                if (!r_gt[0]) begin
                    w_head_prio = r_prio;
                    w_head_data = r_data;
                end
            end
        end else begin
            if (r_count == '0) begin
                w_status = ST_EMPTY;
            end else if (!r_found) begin
                w_status = ST_NOT_FOUND;
            end else begin
                w_status = ST_DONE;
            end
            if (r_found) begin
                n_count = r_count - CW'(1);
                if (!r_gt[0]) begin
                    w_head_prio = r_slot_prio[1];
                    w_head_data = r_slot_data[1];
                end
            end
        end
        if (n_count == '0) begin
            w_head_prio = '0;
            w_head_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req.operation;
            r_prio <= PW'(i_req.priority_req);
            r_data <= DW'(i_req.payload);
        end
        if (i_cmd.compare) begin
            r_found <= w_any_eq;
        end
        if (i_cmd.commit) begin
            r_result.status        <= w_status;
            r_result.head_priority <= PRIO_W'(w_head_prio);
            r_result.head_payload  <= DATA_W'(w_head_data);
            r_result.entry_total   <= TOTAL_W'(n_count);
            r_result.is_empty      <= (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    assign o_result = r_result;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue: top level with stream ports
// Keeps up to CAPACITY entries in descending priority order, head first. Each
// request (insert or remove-by-priority) is handled in steps: register the
// request, compare every slot against it in parallel, then shift the table and
// load the result register; this last step waits while the previous result has
// not yet been taken downstream. A new request is taken in the cycle after the
// previous result is loaded, even while that result still waits downstream;
// requests are handled one at a time. Equal priorities are inserted ahead of
// existing ones; inserts into a full table are dropped with status full.
`include "assert_macros.svh"
module sorted_priority_queue import spq_pkg::*; #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 16,
    parameter int PAYLOAD_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // operation[0], priority_req[16:1], payload[48:17], zero[55:49]
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // status[1:0], head_priority[17:2], head_payload[49:18], entry_total[54:50],
    // is_empty[55]
    output logic [55:0] o_m_axis_tdata
);

    t_cmd    w_cmd;
    t_req    w_req;
    t_result w_result;

    assign w_req = t_req'(i_s_axis_tdata[$bits(t_req)-1:0]);

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    spq_table #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_req    (w_req),
        .o_result (w_result)
    );

    assign o_m_axis_tdata = 56'(w_result);

    `ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "request taken while busy")
    `ASSERT_SAME(a_total_bound, o_m_axis_tvalid && (CAPACITY < 32), w_result.entry_total <= TOTAL_W'(CAPACITY), "entry total beyond capacity")
    `ASSERT_SAME(a_empty_flag, o_m_axis_tvalid, w_result.is_empty == (w_result.entry_total == '0) || (CAPACITY >= 32), "empty flag disagrees with total")
    `ASSERT_SAME(a_empty_head, o_m_axis_tvalid && w_result.is_empty, w_result.head_priority == '0 && w_result.head_payload == '0, "empty queue shows a head")

endmodule
